>>> rtl/nir_pkg.sv
package nir_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_READ  = 2'd1,
    PH_READY = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    FUNC_PAIR = 2'd0,
    FUNC_TICK = 2'd1,
    FUNC_READ = 2'd2
  } func_e;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_EDGE_TIMEOUT  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_WINDOW = 2'd1;

  localparam logic [7:0] EDGE_TIMEOUT_RST  = 8'd16;
  localparam logic [7:0] REPEAT_WINDOW_RST = 8'd120;

  localparam int unsigned TickW = 12;

  // Tick windows at 250 ticks per ms (one tick is 4 us).
  localparam logic [TickW-1:0] LEAD_MARK_LO   = 12'd1750;
  localparam logic [TickW-1:0] LEAD_MARK_HI   = 12'd2750;
  localparam logic [TickW-1:0] LEAD_SPACE_LO  = 12'd800;
  localparam logic [TickW-1:0] LEAD_SPACE_HI  = 12'd1500;
  localparam logic [TickW-1:0] RPT_SPACE_LO   = 12'd400;
  localparam logic [TickW-1:0] BIT_MARK_LO    = 12'd90;
  localparam logic [TickW-1:0] BIT_MARK_HI    = 12'd190;
  localparam logic [TickW-1:0] ONE_SPACE_LO   = 12'd375;
  localparam logic [TickW-1:0] ONE_SPACE_HI   = 12'd475;
  localparam logic [TickW-1:0] ZERO_SPACE_LO  = 12'd90;
  localparam logic [TickW-1:0] ZERO_SPACE_HI  = 12'd190;

  localparam logic [5:0] FRAME_BITS = 6'd32;
  localparam logic [8:0] CHECK_SUM  = 9'd255;
  localparam logic [7:0] RPT_MAX    = 8'd255;

endpackage

>>> rtl/nec_ir_frame_decoder.sv
// NEC infrared frame decoder.
// Input channel (in_valid_i / in_ready_o) carries one item per handshake:
// a measured mark/space pair, a 1 ms tick, or a read request (func_i).
// Output channel (out_valid_o / out_ready_i) returns exactly one result
// item per input item, in order: the packet fields when a read request
// finds a ready packet (zeros otherwise) and the decoder phase after it.
// An accepted item is held in the input register, is decoded by short
// compare and shift-in logic, and lands in the result register, from
// which its result is offered. One item is accepted every cycle as long
// as the result register drains.
// When the receiver stalls, the result register holds its item, the input
// register holds the next one, and in_ready_o drops once both are full.
// The two configuration registers are written through cfg_we_i with no
// handshake; they must only change while no item is in flight.
// Reset clears the decoder state and both pipeline valid flags, and loads
// the edge timeout with 16 ms and the repeat window with 120 ms.
module nec_ir_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [11:0] mark_ticks_i,
  input  logic [11:0] space_ticks_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        packet_valid_o,
  output logic [7:0]  address_o,
  output logic [7:0]  command_o,
  output logic [7:0]  repeat_count_o,
  output logic [1:0]  phase_o
);

  // Configuration.
  logic [7:0] edge_timeout_q, repeat_window_q;

  // Input register.
  logic        s1_valid_q;
  logic [1:0]  s1_func_q;
  logic [11:0] s1_mark_q, s1_space_q;

  // Decoder state.
  nir_pkg::phase_e phase_q, phase_d;
  logic [5:0] bits_q, bits_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] cmd_inv_q, cmd_inv_d;
  logic [7:0] rpt_q, rpt_d;
  logic       rpt_allowed_q, rpt_allowed_d;
  logic       armed_q, armed_d;
  logic [7:0] count_q, count_d;

  // Result register.
  logic       out_valid_q;
  logic       res_pkt_d, res_pkt_q;
  logic [7:0] res_addr_d, res_addr_q;
  logic [7:0] res_cmd_d, res_cmd_q;
  logic [7:0] res_rpt_d, res_rpt_q;
  logic [1:0] res_phase_q;

  logic adv, fire;

  assign adv        = !out_valid_q || out_ready_i;
  assign fire       = s1_valid_q && adv;
  assign in_ready_o = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_timeout_q  <= nir_pkg::EDGE_TIMEOUT_RST;
      repeat_window_q <= nir_pkg::REPEAT_WINDOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        nir_pkg::CFG_EDGE_TIMEOUT:  edge_timeout_q  <= cfg_wdata_i;
        nir_pkg::CFG_REPEAT_WINDOW: repeat_window_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_func_q  <= func_i;
      s1_mark_q  <= mark_ticks_i;
      s1_space_q <= space_ticks_i;
    end
  end

  always_comb begin
    logic       lead_mark, bit_mark;
    logic [2:0] pos;
    logic [7:0] mask;
    logic [8:0] sum;

    phase_d       = phase_q;
    bits_d        = bits_q;
    addr_d        = addr_q;
    cmd_d         = cmd_q;
    cmd_inv_d     = cmd_inv_q;
    rpt_d         = rpt_q;
    rpt_allowed_d = rpt_allowed_q;
    armed_d       = armed_q;
    count_d       = count_q;
    res_pkt_d     = 1'b0;
    res_addr_d    = '0;
    res_cmd_d     = '0;
    res_rpt_d     = '0;

    lead_mark = (s1_mark_q > nir_pkg::LEAD_MARK_LO) && (s1_mark_q < nir_pkg::LEAD_MARK_HI);
    bit_mark  = (s1_mark_q > nir_pkg::BIT_MARK_LO) && (s1_mark_q < nir_pkg::BIT_MARK_HI);
    pos       = bits_q[2:0];
    mask      = 8'd1 << pos;
    sum       = '0;

    case (nir_pkg::func_e'(s1_func_q))
      nir_pkg::FUNC_PAIR: begin
        if (phase_q != nir_pkg::PH_READY) begin
          if (s1_mark_q == '0) begin
            phase_d = nir_pkg::PH_IDLE;
            bits_d = '0; addr_d = '0; cmd_d = '0; cmd_inv_d = '0; rpt_d = '0;
            rpt_allowed_d = 1'b0; armed_d = 1'b0; count_d = '0;
          end else begin
            armed_d = 1'b1;
            count_d = edge_timeout_q;
            if (s1_space_q != '0) begin
              if (lead_mark) begin
                if ((s1_space_q > nir_pkg::LEAD_SPACE_LO) &&
                    (s1_space_q < nir_pkg::LEAD_SPACE_HI)) begin
                  bits_d = '0; addr_d = '0; cmd_d = '0; cmd_inv_d = '0; rpt_d = '0;
                  phase_d = nir_pkg::PH_READ;
                end else if ((s1_space_q > nir_pkg::RPT_SPACE_LO) &&
                             (s1_space_q <= nir_pkg::LEAD_SPACE_LO)) begin
                  if (rpt_allowed_q && (phase_q == nir_pkg::PH_IDLE)) begin
                    if (rpt_q != nir_pkg::RPT_MAX) rpt_d = rpt_q + 8'd1;
                    phase_d = nir_pkg::PH_READY;
                    count_d = repeat_window_q;
                  end else begin
                    phase_d = nir_pkg::PH_IDLE;
                    bits_d = '0; addr_d = '0; cmd_d = '0; cmd_inv_d = '0; rpt_d = '0;
                    rpt_allowed_d = 1'b0; armed_d = 1'b0; count_d = '0;
                  end
                end
              end else if (bit_mark) begin
                if ((phase_q == nir_pkg::PH_READ) &&
                    (((s1_space_q > nir_pkg::ONE_SPACE_LO) &&
                      (s1_space_q < nir_pkg::ONE_SPACE_HI)) ||
                     ((s1_space_q > nir_pkg::ZERO_SPACE_LO) &&
                      (s1_space_q < nir_pkg::ZERO_SPACE_HI)))) begin
                  if (s1_space_q > nir_pkg::ONE_SPACE_LO) begin
                    if (bits_q < 6'd8) addr_d = addr_q | mask;
                    else if (bits_q >= 6'd16 && bits_q < 6'd24) cmd_d = cmd_q | mask;
                    else if (bits_q >= 6'd24) cmd_inv_d = cmd_inv_q | mask;
                  end
                  bits_d = bits_q + 6'd1;
                  if (bits_d == nir_pkg::FRAME_BITS) begin
                    sum = {1'b0, cmd_d} + {1'b0, cmd_inv_d};
                    if (sum == nir_pkg::CHECK_SUM) begin
                      bits_d = '0;
                      phase_d = nir_pkg::PH_READY;
                      rpt_allowed_d = 1'b1;
                      count_d = repeat_window_q;
                    end else begin
                      phase_d = nir_pkg::PH_IDLE;
                      bits_d = '0; addr_d = '0; cmd_d = '0; cmd_inv_d = '0; rpt_d = '0;
                      rpt_allowed_d = 1'b0; armed_d = 1'b0; count_d = '0;
                    end
                  end
                end
              end else begin
                phase_d = nir_pkg::PH_IDLE;
                bits_d = '0; addr_d = '0; cmd_d = '0; cmd_inv_d = '0; rpt_d = '0;
                rpt_allowed_d = 1'b0; armed_d = 1'b0; count_d = '0;
              end
            end
          end
        end
      end
      nir_pkg::FUNC_TICK: begin
        if (armed_q) begin
          if (count_q > 8'd1) begin
            count_d = count_q - 8'd1;
          end else begin
            count_d = '0;
            armed_d = 1'b0;
            if (phase_q == nir_pkg::PH_READY) begin
              rpt_allowed_d = 1'b0;
            end else begin
              phase_d = nir_pkg::PH_IDLE;
              bits_d = '0; addr_d = '0; cmd_d = '0; cmd_inv_d = '0; rpt_d = '0;
              rpt_allowed_d = 1'b0;
            end
          end
        end
      end
      nir_pkg::FUNC_READ: begin
        if (phase_q == nir_pkg::PH_READY) begin
          res_pkt_d  = 1'b1;
          res_addr_d = addr_q;
          res_cmd_d  = cmd_q;
          res_rpt_d  = rpt_q;
          phase_d    = nir_pkg::PH_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= nir_pkg::PH_IDLE;
      bits_q        <= '0;
      addr_q        <= '0;
      cmd_q         <= '0;
      cmd_inv_q     <= '0;
      rpt_q         <= '0;
      rpt_allowed_q <= 1'b0;
      armed_q       <= 1'b0;
      count_q       <= '0;
    end else if (fire) begin
      phase_q       <= phase_d;
      bits_q        <= bits_d;
      addr_q        <= addr_d;
      cmd_q         <= cmd_d;
      cmd_inv_q     <= cmd_inv_d;
      rpt_q         <= rpt_d;
      rpt_allowed_q <= rpt_allowed_d;
      armed_q       <= armed_d;
      count_q       <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_pkt_q   <= res_pkt_d;
      res_addr_q  <= res_addr_d;
      res_cmd_q   <= res_cmd_d;
      res_rpt_q   <= res_rpt_d;
      res_phase_q <= phase_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign packet_valid_o = res_pkt_q;
  assign address_o      = res_addr_q;
  assign command_o      = res_cmd_q;
  assign repeat_count_o = res_rpt_q;
  assign phase_o        = res_phase_q;

  // A delivered packet always leaves the decoder idle.
  a_pkt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_valid_o |-> phase_o == nir_pkg::PH_IDLE)
    else $error("packet result without idle phase");

  // A disarmed timer never keeps a stale countdown.
  a_timer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !armed_q |-> count_q == '0)
    else $error("countdown left while timer disarmed");

  // The bit counter wraps at the end of every frame.
  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q < nir_pkg::FRAME_BITS)
    else $error("bit counter beyond frame length");

  // Reading bits is only entered through a leader, which clears the repeats.
  a_read_rpt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == nir_pkg::PH_READ |-> rpt_q == '0)
    else $error("repeat count kept while reading a frame");

  // Decoder state moves only when an item is processed.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(phase_q) && $stable(bits_q) && $stable(rpt_q))
    else $error("decoder state changed without an item");

endmodule
